// File: rtl/bitmap_block_allocator_macros.svh
// ----------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bba check failed");

// Next-cycle implication, disabled during reset
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bba check failed");

`endif

// File: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Widths, request and status codes, controller states and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  // Default map size and fixed field widths
  localparam int NUM_BLOCKS_DEF = 1024;
  localparam int INDEX_LIMIT    = 1024;
  localparam int BLK_W          = 10;
  localparam int CNT_W          = 11;
  localparam int WORD_W         = 32;
  localparam int BIT_W          = 5;

  // Request kinds
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_EVAL,
    S_DONE
  } bba_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture a new request word
    logic advance;  // step the scan pointer
    logic commit;   // update map and count, latch the result
    logic emit;     // move the result into the output register
  } bba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic alloc;     // current request is an allocate
    logic hit;       // word under test holds a free block
    logic last;      // word under test is the last map word
    logic out_busy;  // output register holds a word that is stalled
  } bba_stat_t;

endpackage

`default_nettype wire

// File: rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator controller
// Sequences load, word scan, commit and result hand-off for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl
  import bba_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bba_stat_t stat,
  output bba_cmd_t  cmd
);

  bba_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        cmd.advance = 1'b1;
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        // an allocate keeps scanning until a free bit shows or the map ends
        if (stat.alloc && !stat.hit && !stat.last) begin
          cmd.advance = 1'b1;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/bba_dpath.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator datapath
// Used-block map in 32-bit words with registered read, first-zero search,
// used-block counter and the result / output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dpath
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bba_cmd_t         cmd,
  output bba_stat_t        stat,
  input  logic [1:0]       in_mode,
  input  logic [BLK_W-1:0] in_block_index,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [BLK_W-1:0] out_granted_block,
  output logic             out_is_free,
  output logic [CNT_W-1:0] out_used_count
);

  localparam int MAP_SPAN  = (NUM_BLOCKS < INDEX_LIMIT) ? NUM_BLOCKS : INDEX_LIMIT;
  localparam int WORDS     = (MAP_SPAN + WORD_W - 1) / WORD_W;
  localparam int WAW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int MEM_DEPTH = 1 << WAW;
  localparam int LAST      = WORDS - 1;
  localparam int TAIL      = MAP_SPAN - LAST * WORD_W;
  localparam logic [WAW-1:0]   LAST_ADDR = WAW'(LAST);
  localparam logic [CNT_W-1:0] SPAN_LIM  = CNT_W'(MAP_SPAN);
  // bits past the end of the map in the last word read as used
  localparam logic [WORD_W:0]  TAIL_FILL =
    ~(((WORD_W+1)'(1) << TAIL) - (WORD_W+1)'(1));

  // Request capture and scan pointer
  logic [1:0]       mode_r;
  logic [BLK_W-1:0] idx_r;
  logic [WAW-1:0]   ptr_r, ptr_nxt;

  // Map storage and read pipeline
  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] wvld_r;
  logic [WORD_W-1:0] rd_word_r;
  logic              rd_vld_r;
  logic [WAW-1:0]    rd_addr_r;

  // Count, result and output registers
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [BLK_W-1:0] res_granted_r, res_granted_nxt;
  logic             res_free_r, res_free_nxt;
  logic [CNT_W-1:0] res_used_r;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [BLK_W-1:0] out_granted_r;
  logic             out_free_r;
  logic [CNT_W-1:0] out_used_r;

  // Word evaluation
  logic [WORD_W-1:0] base_word, scan_word, wr_word;
  logic [BIT_W-1:0]  pos;
  logic              hit, idx_bit, in_map, wr_en;

  // Capture request, step the pointer
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.load) begin
      ptr_nxt = (in_mode == MODE_ALLOC) ? '0 : in_block_index[BIT_W +: WAW];
    end else if (cmd.advance && mode_r == MODE_ALLOC && ptr_r != LAST_ADDR) begin
      ptr_nxt = ptr_r + WAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      idx_r  <= in_block_index;
    end
  end

  // Map memory: one write port, registered read at the scan pointer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[rd_addr_r] <= wr_word;
    end
    rd_word_r <= mem[ptr_r];
  end

  // Word valid bits; an unwritten word reads as its reset pattern
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r    <= '0;
      rd_vld_r  <= 1'b0;
      rd_addr_r <= '0;
    end else begin
      if (wr_en) begin
        wvld_r[rd_addr_r] <= 1'b1;
      end
      rd_vld_r  <= wvld_r[ptr_r];
      rd_addr_r <= ptr_r;
    end
  end

  assign base_word = rd_vld_r ? rd_word_r :
                     ((rd_addr_r == '0) ? WORD_W'(1) : '0);
  assign scan_word = base_word |
                     ((rd_addr_r == LAST_ADDR) ? TAIL_FILL[WORD_W-1:0] : '0);
  assign hit       = ~&scan_word;
  assign idx_bit   = base_word[idx_r[BIT_W-1:0]];
  assign in_map    = {1'b0, idx_r} < SPAN_LIM;

  // Find the lowest clear bit
  always_comb begin
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!scan_word[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  // Resolve the request against the word under test
  always_comb begin
    wr_en           = 1'b0;
    wr_word         = base_word;
    used_nxt        = used_r;
    res_status_nxt  = ST_OK;
    res_granted_nxt = '0;
    res_free_nxt    = 1'b0;
    unique case (mode_r)
      MODE_ALLOC: begin
        if (hit) begin
          wr_en           = cmd.commit;
          wr_word         = base_word | (WORD_W'(1) << pos);
          used_nxt        = used_r + CNT_W'(1);
          res_granted_nxt = (BLK_W'(rd_addr_r) << BIT_W) | BLK_W'(pos);
        end else begin
          res_status_nxt = ST_FULL;
        end
      end
      MODE_FREE: begin
        if (idx_r == '0 || !in_map) begin
          res_status_nxt = ST_INVALID;
        end else if (idx_bit) begin
          wr_en   = cmd.commit;
          wr_word = base_word & ~(WORD_W'(1) << idx_r[BIT_W-1:0]);
          if (used_r != '0) begin
            used_nxt = used_r - CNT_W'(1);
          end
        end
      end
      MODE_QUERY: begin
        if (!in_map) begin
          res_status_nxt = ST_INVALID;
        end else begin
          res_free_nxt = ~idx_bit;
        end
      end
      default: begin
        res_status_nxt = ST_INVALID;
      end
    endcase
  end

  // Used-block count, starts with the reserved block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= CNT_W'(1);
    end else if (cmd.commit) begin
      used_r <= used_nxt;
    end
  end

  // Latch the result
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status_r  <= res_status_nxt;
      res_granted_r <= res_granted_nxt;
      res_free_r    <= res_free_nxt;
      res_used_r    <= used_nxt;
    end
  end

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r  <= res_status_r;
      out_granted_r <= res_granted_r;
      out_free_r    <= res_free_r;
      out_used_r    <= res_used_r;
    end
  end

  assign stat.alloc    = (mode_r == MODE_ALLOC);
  assign stat.hit      = hit;
  assign stat.last     = (rd_addr_r == LAST_ADDR);
  assign stat.out_busy = out_valid_r && out_stall;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_block = out_granted_r;
  assign out_is_free       = out_free_r;
  assign out_used_count    = out_used_r;

endmodule

`default_nettype wire

// File: rtl/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator, first fit.
// Input channel (in_valid / in_stall): one request word per item, in_mode
// selects allocate, free or query, in_block_index names the block for free
// and query. Result channel (out_valid / out_stall): one result word per
// request with status, granted block, free flag and used-block count.
// The map is kept as 32-bit words in a small memory with a registered read;
// one request is worked at a time.
// After accept, each request passes the fill, evaluate and done states; free,
// query and unused modes leave evaluate at once, while an allocate stays in
// it until the word under test holds a free block or is the last map word.
// The scan of the map memory, one word per cycle, sets the allocate time.
// A new request is accepted once the previous result has been loaded into
// the output register, even while that result is still stalled, so the
// next request can be worked while a result waits to be taken.
// Reset leaves block 0 used and all others free, used count 1; the map
// needs no clearing pass. A stalled result holds in the output register and
// the next request completes only once that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_mode,
  input  logic [BLK_W-1:0] in_block_index,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [BLK_W-1:0] out_granted_block,
  output logic             out_is_free,
  output logic [CNT_W-1:0] out_used_count
);

  bba_cmd_t  cmd;
  bba_stat_t stat;

  // Request sequencer
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Map, counter and result registers
  bba_dpath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (in_mode),
    .in_block_index    (in_block_index),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_block (out_granted_block),
    .out_is_free       (out_is_free),
    .out_used_count    (out_used_count)
  );

endmodule

`default_nettype wire

// File: rtl/bba_checker.sv
// ----------------------------------------------------------------------------
// Bitmap block allocator port checker
// Watches the result channel for word hold and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_block_allocator_macros.svh"

module bba_checker
  import bba_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic [1:0]       out_status,
  input wire logic [BLK_W-1:0] out_granted_block,
  input wire logic             out_is_free,
  input wire logic [CNT_W-1:0] out_used_count
);

  // Stalled result word holds
  `BBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_granted_block) && $stable(out_used_count))

  // Reserved block keeps the count at one or more
  `BBA_ASSERT_IMPLY(a_count_range, clk, rst_n, out_valid, out_used_count != '0 && out_used_count <= CNT_W'(INDEX_LIMIT))

  // Full map grants nothing and reports no free block
  `BBA_ASSERT_IMPLY(a_full_no_grant, clk, rst_n, out_valid && out_status == ST_FULL, out_granted_block == '0 && !out_is_free)

  // A grant is a successful allocate
  `BBA_ASSERT_IMPLY(a_grant_ok, clk, rst_n, out_valid && out_granted_block != '0, out_status == ST_OK && !out_is_free && out_used_count >= CNT_W'(2))

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);

`default_nettype wire
